// ===== rtl/umv_pkg.sv =====
// umv_pkg: shared widths, constants and types of the ultrasonic median validator
// used by every module of the block; depends on nothing

`default_nettype none

package umv_pkg;

    localparam int ECHO_W      = 16;
    localparam int DIST_W      = 11;
    localparam int LIMIT_W     = 8;
    localparam int COUNT_WIDTH = 8;
    localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = DIST_W;

    // divide by 58 as multiply by ceil(2^22 / 58) and shift, exact for 16-bit echoes
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] DIV58_RECIP = 17'd72316;
    localparam int DIV58_SHIFT = 22;
    localparam int PROD_W      = ECHO_W + RECIP_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ring slots
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;
    localparam logic [1:0] FILL_FULL = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_NEEDED  = 4'd3;

    // register reset values
    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST  = 11'd2;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST  = 11'd400;
    localparam logic [LIMIT_W-1:0] FAILURE_LIMIT_RST = 8'd3;
    localparam logic [LIMIT_W-1:0] VALID_NEEDED_RST  = 8'd3;

    // largest distance a 16-bit echo can give
    localparam logic [DIST_W-1:0] DIST_MAX = 11'd1129;

    typedef struct packed {
        logic [DIST_W-1:0]  min_distance;
        logic [DIST_W-1:0]  max_distance;
        logic [LIMIT_W-1:0] failure_limit;
        logic [LIMIT_W-1:0] valid_needed;
    } umv_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/umv_div58.sv =====
// umv_div58: input register stage, converts echo time to centimetres (divide by 58)
// depends on umv_pkg

`default_nettype none

module umv_div58 (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [umv_pkg::ECHO_W-1:0]   in_echo,
    output logic                              cm_valid,
    input  wire logic                         cm_ready,
    output logic [umv_pkg::DIST_W-1:0]        cm
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [umv_pkg::DIST_W-1:0]    cm_reg;
    logic [umv_pkg::PROD_W-1:0]    product;
    logic [umv_pkg::DIST_W-1:0]    quotient;

    assign product  = umv_pkg::PROD_W'(in_echo) * umv_pkg::PROD_W'(umv_pkg::DIV58_RECIP);
    assign quotient = umv_pkg::DIST_W'(product >> umv_pkg::DIV58_SHIFT);

    assign in_ready = !valid_reg || cm_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cm_reg <= quotient;
        end
    end

    assign cm_valid = valid_reg;
    assign cm       = cm_reg;

endmodule

`default_nettype wire

// ===== rtl/umv_filter.sv =====
// umv_filter: range check, failure/valid run counters, three-slot median ring
// and the result register; depends on umv_pkg

`default_nettype none

module umv_filter (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire umv_pkg::umv_cfg_t          cfg,
    input  wire logic                       cm_valid,
    output logic                            cm_ready,
    input  wire logic [umv_pkg::DIST_W-1:0] cm,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [umv_pkg::DIST_W-1:0]      out_distance_cm,
    output logic                            out_distance_ok,
    output logic                            out_sample_taken
);

    localparam int DW = umv_pkg::DIST_W;
    localparam int CW = umv_pkg::COUNT_WIDTH;
    localparam int KW = umv_pkg::CMP_W;

    logic [DW-1:0] ring_reg [3];
    logic [DW-1:0] ring_next [3];
    logic [1:0]    ptr_reg, ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic [CW-1:0] fail_reg, fail_next;
    logic [CW-1:0] vrun_reg, vrun_next;
    logic [DW-1:0] held_reg, held_next;
    logic          trust_reg, trust_next;
    logic          taken_reg, taken_next;
    logic          valid_reg, valid_next;

    logic          step;
    logic          in_range;
    logic [1:0]    slot;
    logic [DW-1:0] lo, hi, med;
    logic [CW-1:0] fail_inc;
    logic [CW-1:0] vrun_inc;
    logic [CW-1:0] vrun_rej;
    logic          trust_rej;

    assign cm_ready = !valid_reg || out_ready;
    assign step     = cm_valid && cm_ready;
    assign in_range = (cm >= cfg.min_distance) && (cm <= cfg.max_distance);
    // pointer code three would map to slot zero
    assign slot     = (ptr_reg == umv_pkg::FILL_FULL) ? umv_pkg::SLOT_0 : ptr_reg;

    assign fail_inc = (fail_reg != umv_pkg::COUNT_MAX) ? fail_reg + CW'(1) : fail_reg;
    assign vrun_inc = (vrun_reg != umv_pkg::COUNT_MAX) ? vrun_reg + CW'(1) : vrun_reg;

    // rejection path: limit check first, then the run length check
    always_comb begin
        vrun_rej  = vrun_reg;
        trust_rej = trust_reg;
        if (KW'(fail_inc) >= KW'(cfg.failure_limit)) begin
            vrun_rej  = '0;
            trust_rej = 1'b0;
        end
        if (KW'(vrun_rej) < KW'(cfg.valid_needed)) begin
            vrun_rej  = '0;
            trust_rej = 1'b0;
        end
    end

    // ring contents after the new sample is written
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ring_next[i] = ring_reg[i];
        end
        if (step && in_range) begin
            ring_next[slot] = cm;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (step && in_range && fill_reg != umv_pkg::FILL_FULL) begin
            fill_next = fill_reg + 2'd1;
        end
    end

    // median over the filled slots of the updated ring
    always_comb begin
        lo = (ring_next[0] < ring_next[1]) ? ring_next[0] : ring_next[1];
        hi = (ring_next[0] < ring_next[1]) ? ring_next[1] : ring_next[0];
        priority if (fill_next <= 2'd1) begin
            med = ring_next[0];
        end else if (fill_next == 2'd2) begin
            med = hi;
        end else if (ring_next[2] <= lo) begin
            med = lo;
        end else if (ring_next[2] >= hi) begin
            med = hi;
        end else begin
            med = ring_next[2];
        end
    end

    always_comb begin
        ptr_next   = ptr_reg;
        fail_next  = fail_reg;
        vrun_next  = vrun_reg;
        held_next  = held_reg;
        trust_next = trust_reg;
        taken_next = taken_reg;
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (step) begin
            valid_next = 1'b1;
            if (in_range) begin
                ptr_next   = (slot == umv_pkg::SLOT_2) ? umv_pkg::SLOT_0 : slot + 2'd1;
                fail_next  = '0;
                held_next  = (cm < med) ? cm : med;
                vrun_next  = vrun_inc;
                trust_next = KW'(vrun_inc) >= KW'(cfg.valid_needed);
                taken_next = 1'b1;
            end else begin
                fail_next  = fail_inc;
                vrun_next  = vrun_rej;
                trust_next = trust_rej;
                taken_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                ring_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            fill_reg  <= '0;
            fail_reg  <= '0;
            vrun_reg  <= '0;
            held_reg  <= '0;
            trust_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                ring_reg[i] <= ring_next[i];
            end
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            fail_reg  <= fail_next;
            vrun_reg  <= vrun_next;
            held_reg  <= held_next;
            trust_reg <= trust_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        taken_reg <= taken_next;
    end

    assign out_valid        = valid_reg;
    assign out_distance_cm  = held_reg;
    assign out_distance_ok  = trust_reg;
    assign out_sample_taken = taken_reg;

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_median_validator.sv =====
// ultrasonic_median_validator: top level, configuration registers and the two stages
// depends on umv_pkg, umv_div58 and umv_filter

// One echo time in, one filtered distance out, one item per clock cycle sustained
// while m_ready is high. An accepted item goes first into the cm register, where
// the echo is divided by 58 through a reciprocal multiply, and then into the
// result register, after the range check, the run counters and the lesser of an
// in-range sample and the median of the three-slot ring. s_ready stays high while
// the result register is empty or being drained. Configuration writes take effect
// at once and are meant for times when no item is in flight.

`default_nettype none

module ultrasonic_median_validator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [umv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [umv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [umv_pkg::ECHO_W-1:0]       s_echo_time_us,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [umv_pkg::DIST_W-1:0]            m_distance_cm,
    output logic                                  m_distance_ok,
    output logic                                  m_sample_taken
);

    umv_pkg::umv_cfg_t            cfg_reg, cfg_next;
    logic                         cm_valid;
    logic                         cm_ready;
    logic [umv_pkg::DIST_W-1:0]   cm;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                umv_pkg::CFG_MIN_DISTANCE:  cfg_next.min_distance  = cfg_wdata;
                umv_pkg::CFG_MAX_DISTANCE:  cfg_next.max_distance  = cfg_wdata;
                umv_pkg::CFG_FAILURE_LIMIT:
                    cfg_next.failure_limit = umv_pkg::LIMIT_W'(cfg_wdata);
                umv_pkg::CFG_VALID_NEEDED:
                    cfg_next.valid_needed  = umv_pkg::LIMIT_W'(cfg_wdata);
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_distance  <= umv_pkg::MIN_DISTANCE_RST;
            cfg_reg.max_distance  <= umv_pkg::MAX_DISTANCE_RST;
            cfg_reg.failure_limit <= umv_pkg::FAILURE_LIMIT_RST;
            cfg_reg.valid_needed  <= umv_pkg::VALID_NEEDED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    umv_div58 u_div58 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_echo  (s_echo_time_us),
        .cm_valid (cm_valid),
        .cm_ready (cm_ready),
        .cm       (cm)
    );

    umv_filter u_filter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .cm_valid         (cm_valid),
        .cm_ready         (cm_ready),
        .cm               (cm),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .out_distance_cm  (m_distance_cm),
        .out_distance_ok  (m_distance_ok),
        .out_sample_taken (m_sample_taken)
    );

endmodule

`default_nettype wire

// ===== rtl/umv_checker.sv =====
// umv_checker: port-level assertions for ultrasonic_median_validator, with its bind
// depends on umv_pkg and the top level's ports

`default_nettype none

module umv_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_ready,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [umv_pkg::DIST_W-1:0]     m_distance_cm,
    input  wire logic                           m_distance_ok,
    input  wire logic                           m_sample_taken
);

    // reset empties the result register
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input stalls only when a result is waiting and not taken
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with free result register");

    // no echo can give more than the largest reachable distance
    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_distance_cm <= umv_pkg::DIST_MAX))
        else $error("distance out of reachable range");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_distance_cm)
            && $stable(m_distance_ok) && $stable(m_sample_taken)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_median_validator umv_checker u_umv_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_distance_cm  (m_distance_cm),
    .m_distance_ok  (m_distance_ok),
    .m_sample_taken (m_sample_taken)
);

`default_nettype wire
